// File: design/path_candidate_cost_defines.svh
// Assertion macros for the path candidate cost block.
`ifndef PATH_CANDIDATE_COST_DEFINES_SVH
`define PATH_CANDIDATE_COST_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define PCC_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("pcc: same-cycle check failed");

// Condition holds in the cycle after the trigger.
`define PCC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pcc: next-cycle check failed");

`endif

// File: design/pcc_pkg.sv
package pcc_pkg;

    // Fixed point format
    localparam int FRAC_BITS  = 16;
    localparam int DIR_W      = 17;
    localparam int JD_W       = FRAC_BITS + 1;
    localparam int CD_W       = 32 + FRAC_BITS;
    localparam int SQRT_STEPS = 32;
    localparam int FRAC_STEPS = FRAC_BITS - 1;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    localparam logic [31:0]      ALL_ONES = '1;
    localparam logic [DIR_W-1:0] DIR_MAX  = '1;

    // Register reset values
    localparam logic [31:0] ACCEL_LIMIT_RST = 32'd327680;
    localparam logic [31:0] WEIGHT_RST      = 32'd65536;
    localparam logic [16:0] EPSILON_RST     = 17'd1;

    typedef enum logic [2:0] {
        CFG_ACCEL_LIMIT      = 3'd0,
        CFG_WEIGHT_DIRECTION = 3'd1,
        CFG_WEIGHT_CURVATURE = 3'd2,
        CFG_WEIGHT_LENGTH    = 3'd3,
        CFG_EPSILON          = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [31:0] accel_limit;
        logic [31:0] weight_direction;
        logic [31:0] weight_curvature;
        logic [31:0] weight_length;
        logic [16:0] epsilon;
    } cfg_t;

    // Item as classified by the front: products and signs
    typedef struct packed {
        logic [2:0][63:0] vv;
        logic [2:0][63:0] tt;
        logic [2:0][63:0] pp;
        logic [2:0]       opp;
        logic [31:0]      kappa;
        logic [31:0]      cand;
        logic [31:0]      up;
    } q_item_t;

    typedef struct packed {
        logic           full;
        logic           empty;
        logic [QCW-1:0] count;
    } q_status_t;

    typedef struct packed {
        logic [DIR_W-1:0] direction_cost;
        logic [31:0]      curvature_cost;
        logic [31:0]      length_cost;
        logic [31:0]      total_cost;
        logic             limit_invalid;
        logic             saturated;
    } res_t;

endpackage

// File: design/pcc_in_if.sv
interface pcc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic [31:0]        peak_curvature;
    logic [31:0]        candidate_length;
    logic [31:0]        upstream_length;

    modport source (
        output valid, vel_x, vel_y, vel_z, tangent_x, tangent_y, tangent_z,
               peak_curvature, candidate_length, upstream_length,
        input  ready
    );
    modport sink (
        input  valid, vel_x, vel_y, vel_z, tangent_x, tangent_y, tangent_z,
               peak_curvature, candidate_length, upstream_length,
        output ready
    );
endinterface

// File: design/pcc_out_if.sv
interface pcc_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] direction_cost;
    logic [31:0] curvature_cost;
    logic [31:0] length_cost;
    logic [31:0] total_cost;
    logic        limit_invalid;
    logic        saturated;

    modport source (
        output valid, direction_cost, curvature_cost, length_cost, total_cost,
               limit_invalid, saturated,
        input  ready
    );
    modport sink (
        input  valid, direction_cost, curvature_cost, length_cost, total_cost,
               limit_invalid, saturated,
        output ready
    );
endinterface

// File: design/path_candidate_cost.sv
// Path candidate scorer. Takes one candidate per transfer on in_ch and returns one
// result per candidate on out_ch, in order: direction, curvature, length and weighted
// total cost in unsigned Q16.16 (direction cost in Q1.16) with saturation flags. A new
// candidate can be taken every clock while out_ch does not stall. The back pipeline
// computes both norms and both quotients in 32 stages of one-bit steps, followed by
// 15 stages that produce the cosine fraction. A 4-entry queue separates the input
// classifier from that pipeline, and an output register holds a finished result while
// out_ch stalls. Configuration registers are written through cfg_we/cfg_index/cfg_wdata
// and must only be changed while no candidate is in flight.
`include "path_candidate_cost_defines.svh"

module path_candidate_cost
    import pcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pcc_in_if.sink      in_ch,
    pcc_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    cfg_t      cfg_reg;
    q_status_t q_stat;
    q_item_t   q_push_item;
    q_item_t   q_head;
    logic      q_push;
    logic      q_pop;
    logic      en;
    logic      back_valid;
    res_t      back_res;
    logic      out_vld_reg;
    res_t      out_res_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_limit      <= ACCEL_LIMIT_RST;
            cfg_reg.weight_direction <= WEIGHT_RST;
            cfg_reg.weight_curvature <= WEIGHT_RST;
            cfg_reg.weight_length    <= WEIGHT_RST;
            cfg_reg.epsilon          <= EPSILON_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ACCEL_LIMIT:      cfg_reg.accel_limit      <= cfg_wdata;
                CFG_WEIGHT_DIRECTION: cfg_reg.weight_direction <= cfg_wdata;
                CFG_WEIGHT_CURVATURE: cfg_reg.weight_curvature <= cfg_wdata;
                CFG_WEIGHT_LENGTH:    cfg_reg.weight_length    <= cfg_wdata;
                CFG_EPSILON:          cfg_reg.epsilon          <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    pcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .q_stat     (q_stat),
        .push_valid (q_push),
        .push_item  (q_push_item)
    );

    pcc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // Back pipeline advances whenever the output register can take a result
    assign en    = !out_vld_reg || out_ch.ready;
    assign q_pop = en && !q_stat.empty;

    pcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .en        (en),
        .in_valid  (!q_stat.empty),
        .in_item   (q_head),
        .out_valid (back_valid),
        .out_res   (back_res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= back_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_res_reg <= back_res;
        end
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.direction_cost = out_res_reg.direction_cost;
    assign out_ch.curvature_cost = out_res_reg.curvature_cost;
    assign out_ch.length_cost    = out_res_reg.length_cost;
    assign out_ch.total_cost     = out_res_reg.total_cost;
    assign out_ch.limit_invalid  = out_res_reg.limit_invalid;
    assign out_ch.saturated      = out_res_reg.saturated;

    // Checks
    `PCC_ASSERT_SAME(a_q_no_overflow, clk, rst_n, q_push, !q_stat.full)
    `PCC_ASSERT_SAME(a_full_blocks_input, clk, rst_n, q_stat.full, !in_ch.ready)
    `PCC_ASSERT_SAME(a_inval_flags, clk, rst_n, out_ch.valid && out_ch.limit_invalid,
                     out_ch.saturated && (out_ch.curvature_cost == ALL_ONES))
    `PCC_ASSERT_NEXT(a_q_fills, clk, rst_n, q_push && !q_pop, q_stat.count != '0)

endmodule

// File: design/pcc_front.sv
module pcc_front
    import pcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pcc_in_if.sink    in_ch,
    input  q_status_t q_stat,
    output logic      push_valid,
    output q_item_t   push_item
);

    logic             accept;
    logic [QCW:0]     pending;
    logic             f1_vld_reg;
    logic [2:0][31:0] mv_reg;
    logic [2:0][31:0] mt_reg;
    logic [2:0]       opp_reg;
    logic [31:0]      kappa_reg;
    logic [31:0]      cand_reg;
    logic [31:0]      up_reg;
    logic             f2_vld_reg;
    q_item_t          f2_reg;
    q_item_t          f2_next;
    logic [2:0][31:0] mv_next;
    logic [2:0][31:0] mt_next;
    logic [2:0]       opp_next;

    // Take a transfer only if the queue can absorb everything in flight
    assign pending = (QCW+1)'(q_stat.count) + (QCW+1)'(f1_vld_reg) + (QCW+1)'(f2_vld_reg);
    assign in_ch.ready = pending < (QCW+1)'(QDEPTH);
    assign accept = in_ch.valid && in_ch.ready;

    // Magnitudes and sign relation
    always_comb
    begin
        mv_next[0] = in_ch.vel_x[31] ? (~in_ch.vel_x + 32'd1) : in_ch.vel_x;
        mv_next[1] = in_ch.vel_y[31] ? (~in_ch.vel_y + 32'd1) : in_ch.vel_y;
        mv_next[2] = in_ch.vel_z[31] ? (~in_ch.vel_z + 32'd1) : in_ch.vel_z;
        mt_next[0] = in_ch.tangent_x[31] ? (~in_ch.tangent_x + 32'd1) : in_ch.tangent_x;
        mt_next[1] = in_ch.tangent_y[31] ? (~in_ch.tangent_y + 32'd1) : in_ch.tangent_y;
        mt_next[2] = in_ch.tangent_z[31] ? (~in_ch.tangent_z + 32'd1) : in_ch.tangent_z;
        opp_next[0] = in_ch.vel_x[31] ^ in_ch.tangent_x[31];
        opp_next[1] = in_ch.vel_y[31] ^ in_ch.tangent_y[31];
        opp_next[2] = in_ch.vel_z[31] ^ in_ch.tangent_z[31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else
        begin
            f1_vld_reg <= accept;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mv_reg    <= mv_next;
            mt_reg    <= mt_next;
            opp_reg   <= opp_next;
            kappa_reg <= in_ch.peak_curvature;
            cand_reg  <= in_ch.candidate_length;
            up_reg    <= in_ch.upstream_length;
        end
    end

    // Squares and velocity-tangent products, three multipliers per lane
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            f2_next.vv[i] = 64'(mv_reg[i]) * 64'(mv_reg[i]);
            f2_next.tt[i] = 64'(mt_reg[i]) * 64'(mt_reg[i]);
            f2_next.pp[i] = 64'(mv_reg[i]) * 64'(mt_reg[i]);
        end
        f2_next.opp   = opp_reg;
        f2_next.kappa = kappa_reg;
        f2_next.cand  = cand_reg;
        f2_next.up    = up_reg;
    end

    always_ff @(posedge clk)
    begin
        if (f1_vld_reg)
        begin
            f2_reg <= f2_next;
        end
    end

    assign push_valid = f2_vld_reg;
    assign push_item  = f2_reg;

endmodule

// File: design/pcc_fifo.sv
module pcc_fifo
    import pcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_item_t   push_item,
    input  logic      pop,
    output q_item_t   head,
    output q_status_t stat
);

    q_item_t        mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_reg + QCW'(push) - QCW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = count_reg == QCW'(QDEPTH);
    assign stat.empty = count_reg == '0;

endmodule

// File: design/pcc_back.sv
module pcc_back
    import pcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    en,
    input  logic    in_valid,
    input  q_item_t in_item,
    output logic    out_valid,
    output res_t    out_res
);

    typedef struct packed {
        logic [63:0] vs2;
        logic [63:0] ts2;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [31:0] kappa;
        logic [31:0] up;
        logic [31:0] lr;
        logic [31:0] llow;
        logic        len_ok;
        logic        len_sat;
    } b0_t;

    typedef struct packed {
        logic [63:0] plo;
        logic [63:0] phi;
        logic [63:0] vs2;
        logic [63:0] ts2;
        logic [63:0] dabs;
        logic        dneg;
        logic [31:0] up;
        logic [31:0] lr;
        logic [31:0] llow;
        logic        len_ok;
        logic        len_sat;
    } b1_t;

    // One step of both square roots and both divisions
    typedef struct packed {
        logic [63:0]     vx;
        logic [63:0]     vr;
        logic [63:0]     tx;
        logic [63:0]     tr;
        logic [CD_W-1:0] cr;
        logic [31:0]     cq;
        logic [31:0]     clow;
        logic [31:0]     lr;
        logic [31:0]     lq;
        logic [31:0]     llow;
        logic [31:0]     up;
        logic [63:0]     dabs;
        logic            dneg;
        logic            csat;
        logic            len_ok;
        logic            len_sat;
    } s_t;

    typedef struct packed {
        logic [63:0] den;
        logic [63:0] dabs;
        logic        dneg;
        logic        dir_ok;
        logic [31:0] jk;
        logic [31:0] jl;
        logic        inval;
        logic        sat;
    } m_t;

    // Fraction divider state for the cosine
    typedef struct packed {
        logic [63:0]          fr;
        logic [FRAC_BITS-1:0] fq;
        logic [63:0]          den;
        logic                 add_half;
        logic                 fixed;
        logic [JD_W-1:0]      fval;
        logic [31:0]          jk;
        logic [31:0]          jl;
        logic                 inval;
        logic                 sat;
    } f_t;

    typedef struct packed {
        logic [63:0]      pd;
        logic [63:0]      pk;
        logic [63:0]      pl;
        logic [DIR_W-1:0] jd;
        logic [31:0]      jk;
        logic [31:0]      jl;
        logic             inval;
        logic             sat;
    } w_t;

    localparam logic [JD_W-1:0] HALF = JD_W'(1) << (FRAC_BITS - 1);
    localparam logic [JD_W-1:0] ONE  = JD_W'(1) << FRAC_BITS;

    logic [CD_W-1:0] dc;
    logic [31:0]     eps32;

    b0_t  b0_next, b0_reg;
    b1_t  b1_next, b1_reg;
    s_t   s_init;
    s_t   s_reg [SQRT_STEPS];
    m_t   m_next, m_reg;
    f_t   n_next, n_reg;
    f_t   f_reg [FRAC_STEPS];
    w_t   w_next, w_reg;
    res_t t_next, t_reg;

    logic b0_vld_reg, b1_vld_reg, b2_vld_reg, m_vld_reg, n_vld_reg, w_vld_reg, t_vld_reg;
    logic s_vld_reg [SQRT_STEPS];
    logic f_vld_reg [FRAC_STEPS];

    logic [95:0]     prod;
    logic [63:0]     s2_vs2_reg, s2_ts2_reg, s2_dabs_reg;
    logic [CD_W-1:0] s2_cr_reg;
    logic [31:0]     s2_clow_reg, s2_up_reg, s2_lr_reg, s2_llow_reg;
    logic            s2_dneg_reg, s2_csat_reg, s2_len_ok_reg, s2_len_sat_reg;

    assign dc    = {cfg.accel_limit, FRAC_BITS'(0)};
    assign eps32 = 32'(cfg.epsilon);

    function automatic s_t s_step(input s_t s, input int k, input logic [CD_W-1:0] d);
        s_t          o;
        logic [63:0] bitv;
        logic [64:0] vsum;
        logic [64:0] tsum;
        logic [CD_W:0] ct;
        logic [32:0] lt;
        o    = s;
        bitv = 64'(1) << (62 - 2 * k);
        vsum = {1'b0, s.vr} + {1'b0, bitv};
        if ({1'b0, s.vx} >= vsum)
        begin
            o.vx = s.vx - vsum[63:0];
            o.vr = (s.vr >> 1) + bitv;
        end
        else
        begin
            o.vr = s.vr >> 1;
        end
        tsum = {1'b0, s.tr} + {1'b0, bitv};
        if ({1'b0, s.tx} >= tsum)
        begin
            o.tx = s.tx - tsum[63:0];
            o.tr = (s.tr >> 1) + bitv;
        end
        else
        begin
            o.tr = s.tr >> 1;
        end
        // Curvature quotient bit
        ct = {s.cr, s.clow[31]};
        if (ct >= {1'b0, d})
        begin
            ct = ct - {1'b0, d};
            o.cq = {s.cq[30:0], 1'b1};
        end
        else
        begin
            o.cq = {s.cq[30:0], 1'b0};
        end
        o.cr   = ct[CD_W-1:0];
        o.clow = {s.clow[30:0], 1'b0};
        // Length quotient bit
        lt = {s.lr, s.llow[31]};
        if (lt >= {1'b0, s.up})
        begin
            lt = lt - {1'b0, s.up};
            o.lq = {s.lq[30:0], 1'b1};
        end
        else
        begin
            o.lq = {s.lq[30:0], 1'b0};
        end
        o.lr   = lt[31:0];
        o.llow = {s.llow[30:0], 1'b0};
        return o;
    endfunction

    function automatic f_t f_step(input f_t f);
        f_t          o;
        logic [64:0] t2;
        o  = f;
        t2 = {f.fr, 1'b0};
        if (t2 >= {1'b0, f.den})
        begin
            t2   = t2 - {1'b0, f.den};
            o.fq = {f.fq[FRAC_BITS-2:0], 1'b1};
        end
        else
        begin
            o.fq = {f.fq[FRAC_BITS-2:0], 1'b0};
        end
        o.fr = t2[63:0];
        return o;
    endfunction

    // Valid chain, all stages move together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_vld_reg <= 1'b0;
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
            n_vld_reg  <= 1'b0;
            w_vld_reg  <= 1'b0;
            t_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            b0_vld_reg <= in_valid;
            b1_vld_reg <= b0_vld_reg;
            b2_vld_reg <= b1_vld_reg;
            m_vld_reg  <= s_vld_reg[SQRT_STEPS-1];
            n_vld_reg  <= m_vld_reg;
            w_vld_reg  <= f_vld_reg[FRAC_STEPS-1];
            t_vld_reg  <= w_vld_reg;
        end
    end

    // Sums of products, length setup
    always_comb
    begin
        logic [31:0] diff;
        logic [63:0] n64;
        b0_next.vs2 = in_item.vv[0] + in_item.vv[1] + in_item.vv[2];
        b0_next.ts2 = in_item.tt[0] + in_item.tt[1] + in_item.tt[2];
        b0_next.pos = '0;
        b0_next.neg = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (in_item.opp[i])
            begin
                b0_next.neg = b0_next.neg + in_item.pp[i];
            end
            else
            begin
                b0_next.pos = b0_next.pos + in_item.pp[i];
            end
        end
        diff             = in_item.cand - in_item.up;
        n64              = 64'(diff) << FRAC_BITS;
        b0_next.kappa    = in_item.kappa;
        b0_next.up       = in_item.up;
        b0_next.lr       = n64[63:32];
        b0_next.llow     = n64[31:0];
        b0_next.len_ok   = (in_item.up >= eps32) && (in_item.up != '0)
                           && (in_item.cand > in_item.up);
        b0_next.len_sat  = n64[63:32] >= in_item.up;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_reg <= b0_next;
        end
    end

    // Partial products of kappa * |v|^2, dot product sign
    always_comb
    begin
        b1_next.plo     = 64'(b0_reg.kappa) * 64'(b0_reg.vs2[31:0]);
        b1_next.phi     = 64'(b0_reg.kappa) * 64'(b0_reg.vs2[63:32]);
        b1_next.vs2     = b0_reg.vs2;
        b1_next.ts2     = b0_reg.ts2;
        b1_next.dneg    = b0_reg.neg > b0_reg.pos;
        b1_next.dabs    = b1_next.dneg ? (b0_reg.neg - b0_reg.pos) : (b0_reg.pos - b0_reg.neg);
        b1_next.up      = b0_reg.up;
        b1_next.lr      = b0_reg.lr;
        b1_next.llow    = b0_reg.llow;
        b1_next.len_ok  = b0_reg.len_ok;
        b1_next.len_sat = b0_reg.len_sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg <= b1_next;
        end
    end

    // Full product and curvature overflow check
    assign prod = {32'b0, b1_reg.plo} + {b1_reg.phi, 32'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_vs2_reg     <= b1_reg.vs2;
            s2_ts2_reg     <= b1_reg.ts2;
            s2_cr_reg      <= prod[CD_W+31:32];
            s2_clow_reg    <= prod[31:0];
            s2_csat_reg    <= prod[95:32] >= 64'(dc);
            s2_dabs_reg    <= b1_reg.dabs;
            s2_dneg_reg    <= b1_reg.dneg;
            s2_up_reg      <= b1_reg.up;
            s2_lr_reg      <= b1_reg.lr;
            s2_llow_reg    <= b1_reg.llow;
            s2_len_ok_reg  <= b1_reg.len_ok;
            s2_len_sat_reg <= b1_reg.len_sat;
        end
    end

    always_comb
    begin
        s_init.vx      = s2_vs2_reg;
        s_init.vr      = '0;
        s_init.tx      = s2_ts2_reg;
        s_init.tr      = '0;
        s_init.cr      = s2_cr_reg;
        s_init.cq      = '0;
        s_init.clow    = s2_clow_reg;
        s_init.lr      = s2_lr_reg;
        s_init.lq      = '0;
        s_init.llow    = s2_llow_reg;
        s_init.up      = s2_up_reg;
        s_init.dabs    = s2_dabs_reg;
        s_init.dneg    = s2_dneg_reg;
        s_init.csat    = s2_csat_reg;
        s_init.len_ok  = s2_len_ok_reg;
        s_init.len_sat = s2_len_sat_reg;
    end

    // Root and quotient steps, one bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_s
        s_t   s_cur;
        logic v_cur;
        if (k == 0)
        begin : g_first
            assign s_cur = s_init;
            assign v_cur = b2_vld_reg;
        end
        else
        begin : g_rest
            assign s_cur = s_reg[k-1];
            assign v_cur = s_vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s_vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                s_vld_reg[k] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[k] <= s_step(s_cur, k, dc);
            end
        end
    end

    // Norm product and final curvature and length costs
    always_comb
    begin
        s_t          sl;
        logic [31:0] vn;
        logic [31:0] tn;
        logic        moving;
        sl            = s_reg[SQRT_STEPS-1];
        vn            = sl.vr[31:0];
        tn            = sl.tr[31:0];
        moving        = vn >= eps32;
        m_next.den    = 64'(vn) * 64'(tn);
        m_next.dabs   = sl.dabs;
        m_next.dneg   = sl.dneg;
        m_next.dir_ok = moving && (tn >= eps32) && (vn != '0) && (tn != '0);
        m_next.inval  = moving && (cfg.accel_limit <= eps32);
        if (!moving)
        begin
            m_next.jk = '0;
        end
        else if (m_next.inval || sl.csat)
        begin
            m_next.jk = ALL_ONES;
        end
        else
        begin
            m_next.jk = sl.cq;
        end
        if (!sl.len_ok)
        begin
            m_next.jl = '0;
        end
        else if (sl.len_sat)
        begin
            m_next.jl = ALL_ONES;
        end
        else
        begin
            m_next.jl = sl.lq;
        end
        m_next.sat = (moving && (m_next.inval || sl.csat)) || (sl.len_ok && sl.len_sat);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= m_next;
        end
    end

    // Direction case split and divider setup
    always_comb
    begin
        logic        big;
        logic [63:0] a;
        big             = m_reg.dabs >= m_reg.den;
        a               = m_reg.dabs;
        n_next.add_half = 1'b0;
        n_next.fixed    = 1'b0;
        n_next.fval     = '0;
        if (!m_reg.dir_ok)
        begin
            n_next.fixed = 1'b1;
        end
        else if (!m_reg.dneg)
        begin
            if (big)
            begin
                n_next.fixed = 1'b1;
            end
            else
            begin
                a = m_reg.den - m_reg.dabs;
            end
        end
        else
        begin
            if (big)
            begin
                n_next.fixed = 1'b1;
                n_next.fval  = ONE;
            end
            else
            begin
                n_next.add_half = 1'b1;
            end
        end
        if (a >= m_reg.den)
        begin
            n_next.fr = a - m_reg.den;
            n_next.fq = FRAC_BITS'(1);
        end
        else
        begin
            n_next.fr = a;
            n_next.fq = '0;
        end
        n_next.den   = m_reg.den;
        n_next.jk    = m_reg.jk;
        n_next.jl    = m_reg.jl;
        n_next.inval = m_reg.inval;
        n_next.sat   = m_reg.sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_next;
        end
    end

    // Cosine fraction bits, one per stage
    for (genvar k = 0; k < FRAC_STEPS; k++)
    begin : g_f
        f_t   f_cur;
        logic v_cur;
        if (k == 0)
        begin : g_first
            assign f_cur = n_reg;
            assign v_cur = n_vld_reg;
        end
        else
        begin : g_rest
            assign f_cur = f_reg[k-1];
            assign v_cur = f_vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                f_vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                f_vld_reg[k] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                f_reg[k] <= f_step(f_cur);
            end
        end
    end

    // Direction cost and weighted terms
    always_comb
    begin
        f_t              fl;
        logic [JD_W-1:0] jd_raw;
        logic            jd_sat;
        fl       = f_reg[FRAC_STEPS-1];
        jd_raw   = fl.fixed ? fl.fval : ((fl.add_half ? HALF : '0) + JD_W'(fl.fq));
        jd_sat   = 32'(jd_raw) > 32'(DIR_MAX);
        w_next.jd    = jd_sat ? DIR_MAX : DIR_W'(jd_raw);
        w_next.pd    = 64'(cfg.weight_direction) * 64'(w_next.jd);
        w_next.pk    = fl.inval ? '0 : 64'(cfg.weight_curvature) * 64'(fl.jk);
        w_next.pl    = 64'(cfg.weight_length) * 64'(fl.jl);
        w_next.jk    = fl.jk;
        w_next.jl    = fl.jl;
        w_next.inval = fl.inval;
        w_next.sat   = fl.sat || jd_sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg <= w_next;
        end
    end

    // Total with saturation
    always_comb
    begin
        logic [65:0] sum;
        logic        clip;
        sum  = 66'(w_reg.pd) + 66'(w_reg.pk) + 66'(w_reg.pl);
        clip = (sum[65:CD_W] != '0) || (w_reg.inval && (cfg.weight_curvature != '0));
        t_next.direction_cost = w_reg.jd;
        t_next.curvature_cost = w_reg.jk;
        t_next.length_cost    = w_reg.jl;
        t_next.total_cost     = clip ? ALL_ONES : sum[CD_W-1:FRAC_BITS];
        t_next.limit_invalid  = w_reg.inval;
        t_next.saturated      = w_reg.sat || clip;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg <= t_next;
        end
    end

    assign out_valid = t_vld_reg;
    assign out_res   = t_reg;

endmodule

// File: bench/path_candidate_cost_tb.sv
`timescale 1ns / 1ps

module path_candidate_cost_tb;
    import pcc_pkg::*;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic [31:0]        kappa;
        logic [31:0]        cand;
        logic [31:0]        up;
    } candidate_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    pcc_in_if  in_ch ();
    pcc_out_if out_ch ();

    path_candidate_cost dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the cost registers
    logic [31:0] sh_accel;
    logic [31:0] sh_w_dir;
    logic [31:0] sh_w_curv;
    logic [31:0] sh_w_len;
    logic [16:0] sh_eps;

    res_t pending_costs[$];
    int   errors;
    int   snd_idle_pct;
    int   rcv_idle_pct;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // floor(sqrt(x)), one result bit per step
    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0]  r;
        logic [63:0]  trial;
        logic [127:0] sq;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            sq = 128'(trial) * 128'(trial);
            if (sq <= 128'(x))
                r = trial;
        end
        return r;
    endfunction

    function automatic logic [63:0] abs32(input logic signed [31:0] s);
        logic signed [63:0] w;
        w = 64'(s);
        return (w < 0) ? 64'(-w) : 64'(w);
    endfunction

    // Expected costs of one candidate under the current register values
    function automatic res_t score_candidate(input candidate_t c);
        res_t         r;
        logic [63:0]  vs2, ts2, pos, neg, mv, mt, vn, tn, d, jd, jl;
        logic [127:0] den, jk, acc, total;
        logic         inval, sat, vneg, tneg;
        logic signed [31:0] va[3];
        logic signed [31:0] ta[3];
        va[0] = c.vx; va[1] = c.vy; va[2] = c.vz;
        ta[0] = c.tx; ta[1] = c.ty; ta[2] = c.tz;
        vs2 = '0; ts2 = '0; pos = '0; neg = '0;
        jd = '0; jk = '0; jl = '0;
        inval = 1'b0; sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            mv = abs32(va[i]);
            mt = abs32(ta[i]);
            vs2 += mv * mv;
            ts2 += mt * mt;
            vneg = va[i][31];
            tneg = ta[i][31];
            if (vneg != tneg) neg += mv * mt;
            else pos += mv * mt;
        end
        vn = int_sqrt(vs2);
        tn = int_sqrt(ts2);

        // direction: (1 - cos) / 2 with clamp
        if (vn >= 64'(sh_eps) && tn >= 64'(sh_eps) && vn != 0 && tn != 0) begin
            den = 128'(vn) * 128'(tn);
            if (pos >= neg) begin
                d = pos - neg;
                jd = (128'(d) >= den) ? 64'd0
                                      : 64'(((den - 128'(d)) << (FRAC_BITS - 1)) / den);
            end else begin
                d = neg - pos;
                jd = (128'(d) >= den) ? (64'd1 << FRAC_BITS)
                    : (64'd1 << (FRAC_BITS - 1)) + 64'((128'(d) << (FRAC_BITS - 1)) / den);
            end
            if (jd > 64'(DIR_MAX)) begin
                jd = 64'(DIR_MAX);
                sat = 1'b1;
            end
        end

        // curvature: kappa * |v|^2 / accel
        if (vn >= 64'(sh_eps)) begin
            if (sh_accel <= 32'(sh_eps)) begin
                jk = 128'(ALL_ONES);
                inval = 1'b1;
                sat = 1'b1;
            end else begin
                jk = (128'(c.kappa) * 128'(vs2)) / (128'(sh_accel) << FRAC_BITS);
                if (jk > 128'(ALL_ONES)) begin
                    jk = 128'(ALL_ONES);
                    sat = 1'b1;
                end
            end
        end

        // length excess relative to upstream
        if (c.up >= 32'(sh_eps) && c.up != 0 && c.cand > c.up) begin
            jl = (64'(c.cand - c.up) << FRAC_BITS) / 64'(c.up);
            if (jl > 64'(ALL_ONES)) begin
                jl = 64'(ALL_ONES);
                sat = 1'b1;
            end
        end

        acc = 128'(sh_w_dir) * 128'(jd) + 128'(sh_w_len) * 128'(jl);
        if (!inval)
            acc += 128'(sh_w_curv) * jk;
        total = acc >> FRAC_BITS;
        if (total > 128'(ALL_ONES) || (inval && sh_w_curv != 0)) begin
            total = 128'(ALL_ONES);
            sat = 1'b1;
        end

        r.direction_cost = jd[DIR_W-1:0];
        r.curvature_cost = jk[31:0];
        r.length_cost    = jl[31:0];
        r.total_cost     = total[31:0];
        r.limit_invalid  = inval;
        r.saturated      = sat;
        return r;
    endfunction

    // Result receiver: random stall and compare against oldest expectation
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk) begin
        res_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_costs.size() == 0) begin
                $display("%0t: unexpected result, total_cost %h", $time, out_ch.total_cost);
                errors++;
            end else begin
                exp_r = pending_costs.pop_front();
                if (out_ch.direction_cost !== exp_r.direction_cost) begin
                    $display("%0t: direction_cost expected %h actual %h", $time,
                             exp_r.direction_cost, out_ch.direction_cost);
                    errors++;
                end
                if (out_ch.curvature_cost !== exp_r.curvature_cost) begin
                    $display("%0t: curvature_cost expected %h actual %h", $time,
                             exp_r.curvature_cost, out_ch.curvature_cost);
                    errors++;
                end
                if (out_ch.length_cost !== exp_r.length_cost) begin
                    $display("%0t: length_cost expected %h actual %h", $time,
                             exp_r.length_cost, out_ch.length_cost);
                    errors++;
                end
                if (out_ch.total_cost !== exp_r.total_cost) begin
                    $display("%0t: total_cost expected %h actual %h", $time,
                             exp_r.total_cost, out_ch.total_cost);
                    errors++;
                end
                if (out_ch.limit_invalid !== exp_r.limit_invalid) begin
                    $display("%0t: limit_invalid expected %b actual %b", $time,
                             exp_r.limit_invalid, out_ch.limit_invalid);
                    errors++;
                end
                if (out_ch.saturated !== exp_r.saturated) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             exp_r.saturated, out_ch.saturated);
                    errors++;
                end
            end
        end
    end

    // One candidate transfer, with random idle cycles ahead of it
    task automatic send_candidate(input candidate_t c);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.vel_x            <= c.vx;
        in_ch.vel_y            <= c.vy;
        in_ch.vel_z            <= c.vz;
        in_ch.tangent_x        <= c.tx;
        in_ch.tangent_y        <= c.ty;
        in_ch.tangent_z        <= c.tz;
        in_ch.peak_curvature   <= c.kappa;
        in_ch.candidate_length <= c.cand;
        in_ch.upstream_length  <= c.up;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_costs.push_back(score_candidate(c));
    endtask

    // Register write once the pipeline has drained
    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        in_ch.valid <= 1'b0;
        while (pending_costs.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ACCEL_LIMIT:      sh_accel  = val;
            CFG_WEIGHT_DIRECTION: sh_w_dir  = val;
            CFG_WEIGHT_CURVATURE: sh_w_curv = val;
            CFG_WEIGHT_LENGTH:    sh_w_len  = val;
            CFG_EPSILON:          sh_eps    = val[16:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0:       return $urandom;
            1:       return 32'h8000_0000 >> $urandom_range(31);
            2:       return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            3:       return 32'($urandom_range(3));
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_comp();
        logic [31:0] w;
        w = rand_word();
        case ($urandom_range(5))
            0:       return w;
            1:       return 32'h8000_0000;
            default: return ($urandom_range(1) != 0) ? -$signed(w >> 1) : $signed(w >> 1);
        endcase
    endfunction

    function automatic candidate_t rand_candidate();
        candidate_t c;
        int         k;
        c.vx = rand_comp();
        c.vy = rand_comp();
        c.vz = rand_comp();
        // tangent often parallel or opposed to velocity to reach the clamp
        case ($urandom_range(3))
            0: begin
                k = $urandom_range(3) + 1;
                c.tx = c.vx / k; c.ty = c.vy / k; c.tz = c.vz / k;
            end
            1: begin
                c.tx = -(c.vx >>> 1); c.ty = -(c.vy >>> 1); c.tz = -(c.vz >>> 1);
            end
            default: begin
                c.tx = rand_comp(); c.ty = rand_comp(); c.tz = rand_comp();
            end
        endcase
        c.kappa = rand_word();
        c.up    = rand_word();
        case ($urandom_range(2))
            0:       c.cand = c.up + ($urandom >> $urandom_range(31));
            1:       c.cand = c.up - $urandom_range(3);
            default: c.cand = rand_word();
        endcase
        return c;
    endfunction

    function automatic candidate_t make_candidate(
        input logic signed [31:0] vx, vy, vz, tx, ty, tz,
        input logic [31:0] kappa, cand, up);
        candidate_t c;
        c.vx = vx; c.vy = vy; c.vz = vz;
        c.tx = tx; c.ty = ty; c.tz = tz;
        c.kappa = kappa; c.cand = cand; c.up = up;
        return c;
    endfunction

    // Corner cases, starting at the reset register values
    task automatic test_directed();
        // aligned, opposed and orthogonal directions
        send_candidate(make_candidate(65536, 0, 0, 131072, 0, 0, 65536, 131072, 65536));
        send_candidate(make_candidate(65536, 0, 0, -65536, 0, 0, 65536, 65536, 131072));
        send_candidate(make_candidate(0, 65536, 0, 65536, 0, 0, 0, 0, 0));
        // standstill and zero tangent
        send_candidate(make_candidate(0, 0, 0, 65536, 65536, 0, 32'hFFFF_FFFF, 5, 0));
        send_candidate(make_candidate(65536, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 7, 3));
        // most negative and most positive components
        send_candidate(make_candidate(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
        send_candidate(make_candidate(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_candidate(make_candidate(-1, 1, -1, 1, -1, 1, 1, 2, 1));
        send_candidate(make_candidate(32'sh7FFF_FFFF, -5, 3, 32'sh7FFF_FFFF, 7, -2,
                                      32'hFFFF_FFFF, 0, 32'hFFFF_FFFF));
        // accel limit at epsilon: invalid, then with curvature weight zero
        write_reg(CFG_ACCEL_LIMIT, 32'd1);
        send_candidate(make_candidate(65536, 0, 0, 65536, 0, 0, 65536, 65536, 65536));
        send_candidate(make_candidate(0, 0, 0, 65536, 0, 0, 65536, 65536, 65536));
        write_reg(CFG_WEIGHT_CURVATURE, 32'd0);
        send_candidate(make_candidate(65536, 0, 0, -65536, 0, 0, 65536, 131072, 65536));
        write_reg(CFG_ACCEL_LIMIT, 32'd0);
        send_candidate(make_candidate(3, 4, 0, 4, 3, 0, 9, 9, 2));
        // large epsilon hides short norms and upstream lengths
        write_reg(CFG_EPSILON, 32'd65536);
        write_reg(CFG_ACCEL_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_WEIGHT_CURVATURE, 32'hFFFF_FFFF);
        send_candidate(make_candidate(65535, 0, 0, 65536, 0, 0, 65536, 65535, 65535));
        send_candidate(make_candidate(65536, 0, 0, 65536, 0, 0, 32'hFFFF_FFFF, 131072, 65536));
        send_candidate(make_candidate(1, 0, 0, 1, 0, 0, 5, 5, 0));
        write_reg(CFG_EPSILON, 32'd0);
        send_candidate(make_candidate(1, 0, 0, -1, 0, 0, 5, 5, 0));
        send_candidate(make_candidate(1, 1, 1, 1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    endtask

    task automatic test_random(input int n);
        repeat (n)
            send_candidate(rand_candidate());
    endtask

    // Random items under a series of register settings
    task automatic test_register_sweep(input int per_setting);
        logic [31:0] wset[4];
        wset[0] = 32'd0;
        wset[1] = 32'hFFFF_FFFF;
        wset[2] = 32'd65536;
        wset[3] = $urandom >> $urandom_range(31);
        for (int s = 0; s < 4; s++) begin
            write_reg(CFG_ACCEL_LIMIT, (s == 1) ? 32'hFFFF_FFFF : rand_word());
            write_reg(CFG_WEIGHT_DIRECTION, wset[s]);
            write_reg(CFG_WEIGHT_CURVATURE, wset[(s + 1) % 4]);
            write_reg(CFG_WEIGHT_LENGTH, wset[(s + 2) % 4]);
            write_reg(CFG_EPSILON, (s == 3) ? 32'd65536 : 32'($urandom_range(65536) >> (s * 5)));
            test_random(per_setting);
        end
        write_reg(CFG_ACCEL_LIMIT, ACCEL_LIMIT_RST);
        write_reg(CFG_WEIGHT_DIRECTION, WEIGHT_RST);
        write_reg(CFG_WEIGHT_CURVATURE, WEIGHT_RST);
        write_reg(CFG_WEIGHT_LENGTH, WEIGHT_RST);
        write_reg(CFG_EPSILON, 32'(EPSILON_RST));
    endtask

    initial begin
        errors       = 0;
        snd_idle_pct = 21;
        rcv_idle_pct = 64;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_ACCEL_LIMIT;
        cfg_wdata    = '0;
        in_ch.valid            = 1'b0;
        in_ch.vel_x            = '0;
        in_ch.vel_y            = '0;
        in_ch.vel_z            = '0;
        in_ch.tangent_x        = '0;
        in_ch.tangent_y        = '0;
        in_ch.tangent_z        = '0;
        in_ch.peak_curvature   = '0;
        in_ch.candidate_length = '0;
        in_ch.upstream_length  = '0;
        sh_accel  = ACCEL_LIMIT_RST;
        sh_w_dir  = WEIGHT_RST;
        sh_w_curv = WEIGHT_RST;
        sh_w_len  = WEIGHT_RST;
        sh_eps    = EPSILON_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_sweep(110);
        test_random(80);

        snd_idle_pct = 64;
        rcv_idle_pct = 21;
        test_register_sweep(110);
        test_random(80);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_register_sweep(110);
        test_random(80);

        in_ch.valid <= 1'b0;
        while (pending_costs.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/pcc_pkg.sv
design/pcc_in_if.sv
design/pcc_out_if.sv
design/pcc_front.sv
design/pcc_fifo.sv
design/pcc_back.sv
design/path_candidate_cost.sv
bench/path_candidate_cost_tb.sv
